// ===== rtl/core/curve25519_field_square_top_assert.svh =====
`ifndef CURVE25519_FIELD_SQUARE_TOP_ASSERT_SVH
`define CURVE25519_FIELD_SQUARE_TOP_ASSERT_SVH

// Same-cycle implication, checked only while reset is released.
`define FSQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only while reset is released.
`define FSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/fsq_pkg.sv =====
package fsq_pkg;

    localparam int LIMB_BITS    = 51;
    localparam int IN_BITS      = 52;
    localparam int HALF_BITS    = 26;
    localparam int PROD_BITS    = 104;
    localparam int SCALED_BITS  = 110;
    localparam int COL_BITS     = 112;
    localparam int CARRY_BITS   = COL_BITS - LIMB_BITS;
    localparam int FOLD_BITS    = 67;
    localparam int NLIMB        = 5;
    localparam int NTERM        = 3;
    localparam int LANE_STAGES  = 4;
    localparam int MERGE_STAGES = 7;
    localparam int NSTAGE       = LANE_STAGES + MERGE_STAGES;

    typedef logic [IN_BITS-1:0]   t_limb;
    typedef t_limb [NLIMB-1:0]    t_limbs;
    typedef t_limb [NTERM-1:0]    t_terms;
    typedef logic [COL_BITS-1:0]  t_col;
    typedef t_col [NLIMB-1:0]     t_cols;
    typedef logic [2:0]           t_idx;

    // Weight applied to a raw limb product: doubling for cross terms and
    // folding by 19 for terms at or above 2^255.
    typedef enum logic [1:0] {
        SC_1,
        SC_2,
        SC_19,
        SC_38
    } t_scale;

    typedef t_scale [NTERM-1:0] t_scales;

    // Column j of the square is sum over t of COL_K * a[COL_X] * a[COL_Y].
    localparam t_idx COL_X [NLIMB][NTERM] = '{
        '{3'd0, 3'd1, 3'd2},
        '{3'd0, 3'd3, 3'd2},
        '{3'd0, 3'd1, 3'd3},
        '{3'd0, 3'd1, 3'd4},
        '{3'd0, 3'd1, 3'd2}
    };

    localparam t_idx COL_Y [NLIMB][NTERM] = '{
        '{3'd0, 3'd4, 3'd3},
        '{3'd1, 3'd3, 3'd4},
        '{3'd2, 3'd1, 3'd4},
        '{3'd3, 3'd2, 3'd4},
        '{3'd4, 3'd3, 3'd2}
    };

    localparam t_scale COL_K [NLIMB][NTERM] = '{
        '{SC_1, SC_38, SC_38},
        '{SC_2, SC_19, SC_38},
        '{SC_2, SC_1,  SC_38},
        '{SC_2, SC_2,  SC_19},
        '{SC_2, SC_2,  SC_1}
    };

endpackage

// ===== rtl/core/fsq_if.sv =====
interface fsq_in_if;
    import fsq_pkg::*;

    logic  valid;
    logic  ready;
    t_limb limb_in0;
    t_limb limb_in1;
    t_limb limb_in2;
    t_limb limb_in3;
    t_limb limb_in4;

    modport source (
        output valid, limb_in0, limb_in1, limb_in2, limb_in3, limb_in4,
        input  ready
    );

    modport sink (
        input  valid, limb_in0, limb_in1, limb_in2, limb_in3, limb_in4,
        output ready
    );
endinterface

interface fsq_out_if;
    import fsq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [LIMB_BITS-1:0] sq_limb0;
    logic [IN_BITS-1:0]   sq_limb1;
    logic [LIMB_BITS-1:0] sq_limb2;
    logic [LIMB_BITS-1:0] sq_limb3;
    logic [LIMB_BITS-1:0] sq_limb4;

    modport source (
        output valid, sq_limb0, sq_limb1, sq_limb2, sq_limb3, sq_limb4,
        input  ready
    );

    modport sink (
        input  valid, sq_limb0, sq_limb1, sq_limb2, sq_limb3, sq_limb4,
        output ready
    );
endinterface

// ===== rtl/core/curve25519_field_square_top.sv =====
// Throughput: one beat per cycle while the output is not stalled; five column
// lanes and a seven-stage carry pipeline each take a new beat every cycle, and
// every stage stalls on its own.
// Input ready drops only when every stage holds a beat and the output is stalled.
// Reset (synchronous, active low) clears the stage valid flags only; the block
// is ready on the first cycle after reset.
`include "curve25519_field_square_top_assert.svh"

module curve25519_field_square_top (
    input logic       i_clk,
    input logic       i_rst_n,
    fsq_in_if.sink    i_in,
    fsq_out_if.source o_out
);
    import fsq_pkg::*;

    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] n_vld;
    logic [NSTAGE-1:0] w_en;
    t_limbs            w_limb;
    t_cols             w_col;

    // A stage may load when it is empty or when the stage after it loads.
    always_comb begin
        w_en[NSTAGE-1] = !r_vld[NSTAGE-1] || o_out.ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
        n_vld = (w_en & {r_vld[NSTAGE-2:0], i_in.valid}) | (~w_en & r_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_in.ready  = w_en[0];
    assign o_out.valid = r_vld[NSTAGE-1];

    assign w_limb[0] = i_in.limb_in0;
    assign w_limb[1] = i_in.limb_in1;
    assign w_limb[2] = i_in.limb_in2;
    assign w_limb[3] = i_in.limb_in3;
    assign w_limb[4] = i_in.limb_in4;

    for (genvar j = 0; j < NLIMB; j++) begin : g_lane
        t_terms  w_x;
        t_terms  w_y;
        t_scales w_k;

        for (genvar t = 0; t < NTERM; t++) begin : g_term
            assign w_x[t] = w_limb[COL_X[j][t]];
            assign w_y[t] = w_limb[COL_Y[j][t]];
            assign w_k[t] = COL_K[j][t];
        end

        fsq_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (w_en[LANE_STAGES-1:0]),
            .i_x     (w_x),
            .i_y     (w_y),
            .i_scale (w_k),
            .o_col   (w_col[j])
        );
    end

    fsq_merge u_merge (
        .i_clk      (i_clk),
        .i_en       (w_en[NSTAGE-1:LANE_STAGES]),
        .i_col      (w_col),
        .o_sq_limb0 (o_out.sq_limb0),
        .o_sq_limb1 (o_out.sq_limb1),
        .o_sq_limb2 (o_out.sq_limb2),
        .o_sq_limb3 (o_out.sq_limb3),
        .o_sq_limb4 (o_out.sq_limb4)
    );

    `FSQ_ASSERT_NOW(a_ready_when_out_empty, i_clk, i_rst_n, !o_out.valid, i_in.ready, "input not ready although the output stage is empty")
    `FSQ_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_in.valid && i_in.ready, r_vld[0], "accepted beat did not enter the first stage")
    `FSQ_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, !(i_in.valid && i_in.ready) && !(o_out.valid && o_out.ready), $countones(r_vld) == $past($countones(r_vld)), "beat count changed without a transfer")
    `FSQ_ASSERT_NEXT(a_count_fill, i_clk, i_rst_n, (i_in.valid && i_in.ready) && !(o_out.valid && o_out.ready), $countones(r_vld) == $past($countones(r_vld)) + 1, "beat count did not grow on input")
    `FSQ_ASSERT_NEXT(a_count_drain, i_clk, i_rst_n, !(i_in.valid && i_in.ready) && (o_out.valid && o_out.ready), $countones(r_vld) + 1 == $past($countones(r_vld)), "beat count did not shrink on output")

endmodule

// ===== rtl/core/fsq_lane.sv =====
module fsq_lane (
    input  logic                             i_clk,
    input  logic [fsq_pkg::LANE_STAGES-1:0]  i_en,
    input  fsq_pkg::t_terms                  i_x,
    input  fsq_pkg::t_terms                  i_y,
    input  fsq_pkg::t_scales                 i_scale,
    output fsq_pkg::t_col                    o_col
);
    import fsq_pkg::*;

    localparam int PP_BITS = 2 * HALF_BITS;

    function automatic logic [SCALED_BITS-1:0] scale_prod(
        input logic [PROD_BITS-1:0] p,
        input t_scale               k
    );
        logic [SCALED_BITS-1:0] w;
        logic [SCALED_BITS-1:0] r;
        w = {{(SCALED_BITS-PROD_BITS){1'b0}}, p};
        case (k)
            SC_1:    r = w;
            SC_2:    r = w << 1;
            SC_19:   r = (w << 4) + (w << 1) + w;
            SC_38:   r = (w << 5) + (w << 2) + (w << 1);
            default: r = w;
        endcase
        return r;
    endfunction

    logic [PP_BITS-1:0]     r_pp_ll [NTERM];
    logic [PP_BITS-1:0]     r_pp_lh [NTERM];
    logic [PP_BITS-1:0]     r_pp_hl [NTERM];
    logic [PP_BITS-1:0]     r_pp_hh [NTERM];
    logic [PROD_BITS-1:0]   n_prod  [NTERM];
    logic [PROD_BITS-1:0]   r_prod  [NTERM];
    logic [SCALED_BITS-1:0] r_scaled [NTERM];
    logic [PP_BITS:0]       w_mid   [NTERM];
    t_col                   n_col;
    t_col                   r_col;

    // Each 52x52 product is cut into four 26x26 partial products.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int t = 0; t < NTERM; t++) begin
                r_pp_ll[t] <= i_x[t][HALF_BITS-1:0] * i_y[t][HALF_BITS-1:0];
                r_pp_lh[t] <= i_x[t][HALF_BITS-1:0] * i_y[t][IN_BITS-1:HALF_BITS];
                r_pp_hl[t] <= i_x[t][IN_BITS-1:HALF_BITS] * i_y[t][HALF_BITS-1:0];
                r_pp_hh[t] <= i_x[t][IN_BITS-1:HALF_BITS] * i_y[t][IN_BITS-1:HALF_BITS];
            end
        end
    end

    always_comb begin
        for (int t = 0; t < NTERM; t++) begin
            w_mid[t]  = {1'b0, r_pp_lh[t]} + {1'b0, r_pp_hl[t]};
            n_prod[t] = {r_pp_hh[t], r_pp_ll[t]}
                      + ({{(PROD_BITS-PP_BITS-1){1'b0}}, w_mid[t]} << HALF_BITS);
        end
        n_col = '0;
        for (int t = 0; t < NTERM; t++) begin
            n_col = n_col + {{(COL_BITS-SCALED_BITS){1'b0}}, r_scaled[t]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_prod <= n_prod;
        end
        if (i_en[2]) begin
            for (int t = 0; t < NTERM; t++) begin
                r_scaled[t] <= scale_prod(r_prod[t], i_scale[t]);
            end
        end
        if (i_en[3]) begin
            r_col <= n_col;
        end
    end

    assign o_col = r_col;

endmodule

// ===== rtl/core/fsq_merge.sv =====
module fsq_merge (
    input  logic                              i_clk,
    input  logic [fsq_pkg::MERGE_STAGES-1:0]  i_en,
    input  fsq_pkg::t_cols                    i_col,
    output logic [fsq_pkg::LIMB_BITS-1:0]     o_sq_limb0,
    output logic [fsq_pkg::IN_BITS-1:0]       o_sq_limb1,
    output logic [fsq_pkg::LIMB_BITS-1:0]     o_sq_limb2,
    output logic [fsq_pkg::LIMB_BITS-1:0]     o_sq_limb3,
    output logic [fsq_pkg::LIMB_BITS-1:0]     o_sq_limb4
);
    import fsq_pkg::*;

    localparam int TOP_BITS = FOLD_BITS - LIMB_BITS;

    typedef logic [LIMB_BITS-1:0]  t_h;
    typedef logic [CARRY_BITS-1:0] t_k;

    // Stage 1: split column 0.
    t_h   r1_h0;
    t_k   r1_k;
    t_col r1_c1, r1_c2, r1_c3, r1_c4;
    // Stages 2 to 5: one column absorbs the running carry per stage.
    t_col n2, n3, n4, n5;
    t_h   r2_h0, r2_h1;
    t_k   r2_k;
    t_col r2_c2, r2_c3, r2_c4;
    t_h   r3_h0, r3_h1, r3_h2;
    t_k   r3_k;
    t_col r3_c3, r3_c4;
    t_h   r4_h0, r4_h1, r4_h2, r4_h3;
    t_k   r4_k;
    t_col r4_c4;
    t_h   r5_h0, r5_h1, r5_h2, r5_h3, r5_h4;
    t_k   r5_k;
    // Stage 6: fold 19 times the top carry into limb 0.
    logic [FOLD_BITS-1:0] w_k_ext;
    logic [FOLD_BITS-1:0] n6;
    t_h                   r6_h0, r6_h1, r6_h2, r6_h3, r6_h4;
    logic [TOP_BITS-1:0]  r6_c;
    // Stage 7: last carry lands in limb 1, which is left lazily reduced.
    logic [IN_BITS-1:0]   n7;
    t_h                   r7_h0, r7_h2, r7_h3, r7_h4;
    logic [IN_BITS-1:0]   r7_h1;

    always_comb begin
        n2      = r1_c1 + {{LIMB_BITS{1'b0}}, r1_k};
        n3      = r2_c2 + {{LIMB_BITS{1'b0}}, r2_k};
        n4      = r3_c3 + {{LIMB_BITS{1'b0}}, r3_k};
        n5      = r4_c4 + {{LIMB_BITS{1'b0}}, r4_k};
        w_k_ext = {{(FOLD_BITS-CARRY_BITS){1'b0}}, r5_k};
        n6      = {{TOP_BITS{1'b0}}, r5_h0} + (w_k_ext << 4) + (w_k_ext << 1) + w_k_ext;
        n7      = {1'b0, r6_h1} + {{(IN_BITS-TOP_BITS){1'b0}}, r6_c};
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_h0 <= i_col[0][LIMB_BITS-1:0];
            r1_k  <= i_col[0][COL_BITS-1:LIMB_BITS];
            r1_c1 <= i_col[1];
            r1_c2 <= i_col[2];
            r1_c3 <= i_col[3];
            r1_c4 <= i_col[4];
        end
        if (i_en[1]) begin
            r2_h0 <= r1_h0;
            r2_h1 <= n2[LIMB_BITS-1:0];
            r2_k  <= n2[COL_BITS-1:LIMB_BITS];
            r2_c2 <= r1_c2;
            r2_c3 <= r1_c3;
            r2_c4 <= r1_c4;
        end
        if (i_en[2]) begin
            r3_h0 <= r2_h0;
            r3_h1 <= r2_h1;
            r3_h2 <= n3[LIMB_BITS-1:0];
            r3_k  <= n3[COL_BITS-1:LIMB_BITS];
            r3_c3 <= r2_c3;
            r3_c4 <= r2_c4;
        end
        if (i_en[3]) begin
            r4_h0 <= r3_h0;
            r4_h1 <= r3_h1;
            r4_h2 <= r3_h2;
            r4_h3 <= n4[LIMB_BITS-1:0];
            r4_k  <= n4[COL_BITS-1:LIMB_BITS];
            r4_c4 <= r3_c4;
        end
        if (i_en[4]) begin
            r5_h0 <= r4_h0;
            r5_h1 <= r4_h1;
            r5_h2 <= r4_h2;
            r5_h3 <= r4_h3;
            r5_h4 <= n5[LIMB_BITS-1:0];
            r5_k  <= n5[COL_BITS-1:LIMB_BITS];
        end
        if (i_en[5]) begin
            r6_h0 <= n6[LIMB_BITS-1:0];
            r6_c  <= n6[FOLD_BITS-1:LIMB_BITS];
            r6_h1 <= r5_h1;
            r6_h2 <= r5_h2;
            r6_h3 <= r5_h3;
            r6_h4 <= r5_h4;
        end
        if (i_en[6]) begin
            r7_h0 <= r6_h0;
            r7_h1 <= n7;
            r7_h2 <= r6_h2;
            r7_h3 <= r6_h3;
            r7_h4 <= r6_h4;
        end
    end

    assign o_sq_limb0 = r7_h0;
    assign o_sq_limb1 = r7_h1;
    assign o_sq_limb2 = r7_h2;
    assign o_sq_limb3 = r7_h3;
    assign o_sq_limb4 = r7_h4;

endmodule
